// ===== rtl/lbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_pkg: shared types and constants for the LED blink mode controller
// Holds the payload structs, mode and register codes, controller commands
// and the blink half-period table.
// ----------------------------------------------------------------------------
package lbm_pkg;

    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PERIOD_BITS    = 9;

    localparam logic [4:0]  FREQ_MAX_CODE      = 5'd31;
    localparam logic [15:0] HEARTBEAT_RESET_MS = 16'd500;
    localparam logic [3:0]  DEFAULT_FREQ_RESET = 4'd2;
    localparam logic [3:0]  MIN_FREQ_RESET     = 4'd1;
    localparam logic [3:0]  MAX_FREQ_RESET     = 4'd5;

    typedef logic [TIME_BITS-1:0] stamp_t;

    typedef enum logic [2:0] {
        MODE_RUN   = 3'd0,
        MODE_ENTRY = 3'd1,
        MODE_SLEEP = 3'd2,
        MODE_RESET = 3'd3,
        MODE_ERROR = 3'd4
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HEARTBEAT_INTERVAL = 2'd0,
        CFG_DEFAULT_FREQ       = 2'd1,
        CFG_MIN_FREQ           = 2'd2,
        CFG_MAX_FREQ           = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EVAL   = 2'd1,
        ST_UPDATE = 2'd2,
        ST_OUT    = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic [NOW_BITS-1:0] now_ms;
        logic                sleep_press;
        logic                up_press;
        logic                down_press;
        logic                reset_press;
    } in_item_t;

    typedef struct packed {
        logic       heartbeat_on;
        logic       pump_on;
        logic       buzzer_on;
        logic       error_on;
        logic [2:0] mode_now;
        logic [4:0] freq_now;
    } res_item_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic update;
    } dp_cmd_t;

    // 1000 / (2 * f) ms, zero frequency treated as one
    function automatic logic [PERIOD_BITS-1:0] half_period_ms(input logic [4:0] f);
        logic [PERIOD_BITS-1:0] p;
        begin
            unique case (f)
                5'd0:  p = 9'd500;
                5'd1:  p = 9'd500;
                5'd2:  p = 9'd250;
                5'd3:  p = 9'd166;
                5'd4:  p = 9'd125;
                5'd5:  p = 9'd100;
                5'd6:  p = 9'd83;
                5'd7:  p = 9'd71;
                5'd8:  p = 9'd62;
                5'd9:  p = 9'd55;
                5'd10: p = 9'd50;
                5'd11: p = 9'd45;
                5'd12: p = 9'd41;
                5'd13: p = 9'd38;
                5'd14: p = 9'd35;
                5'd15: p = 9'd33;
                5'd16: p = 9'd31;
                5'd17: p = 9'd29;
                5'd18: p = 9'd27;
                5'd19: p = 9'd26;
                5'd20: p = 9'd25;
                5'd21: p = 9'd23;
                5'd22: p = 9'd22;
                5'd23: p = 9'd21;
                5'd24: p = 9'd20;
                5'd25: p = 9'd20;
                5'd26: p = 9'd19;
                5'd27: p = 9'd18;
                5'd28: p = 9'd17;
                5'd29: p = 9'd17;
                5'd30: p = 9'd16;
                5'd31: p = 9'd16;
                default: p = 9'd500;
            endcase
            return p;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lbm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_ctrl: tick sequencer
// Walks one tick through capture, compare, update and result transfer.
// ----------------------------------------------------------------------------
module lbm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output lbm_pkg::dp_cmd_t     cmd
);
    import lbm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_OUT;
            ST_OUT:    if (!res_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        res_valid  = (state_reg == ST_OUT);
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.eval   = (state_reg == ST_EVAL);
        cmd.update = (state_reg == ST_UPDATE);
    end

endmodule
`default_nettype wire

// ===== rtl/lbm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_datapath: mode, frequency, timer and LED state
// Holds the configuration, compares elapsed times and applies one tick.
// ----------------------------------------------------------------------------
module lbm_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire lbm_pkg::dp_cmd_t                      cmd,
    input  wire lbm_pkg::in_item_t                     in_item,
    input  wire logic                                  cfg_we,
    input  wire logic [lbm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [lbm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output lbm_pkg::res_item_t                         res_item
);
    import lbm_pkg::*;

    logic [15:0] interval_reg;
    logic [3:0]  dflt_freq_reg;
    logic [3:0]  min_freq_reg;
    logic [3:0]  max_freq_reg;

    stamp_t      now_reg;
    logic        sleep_press_reg;
    logic        up_press_reg;
    logic        down_press_reg;
    logic        reset_press_reg;
    logic        heart_fire_reg;
    logic        pump_fire_reg;

    mode_t       mode_reg,       mode_next;
    logic [4:0]  freq_reg,       freq_next;
    logic        heart_level_reg, heart_level_next;
    stamp_t      heart_stamp_reg, heart_stamp_next;
    logic        pump_phase_reg, pump_phase_next;
    stamp_t      pump_stamp_reg, pump_stamp_next;
    logic        pump_pin_reg,   pump_pin_next;
    logic        buzzer_pin_reg, buzzer_pin_next;
    logic        error_pin_reg,  error_pin_next;
    logic        adjust_en_reg,  adjust_en_next;
    logic        sleep_en_reg,   sleep_en_next;

    stamp_t      heart_elapsed;
    stamp_t      pump_elapsed;
    logic [4:0]  freq_mid;
    logic [4:0]  freq_up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= HEARTBEAT_RESET_MS;
            dflt_freq_reg <= DEFAULT_FREQ_RESET;
            min_freq_reg  <= MIN_FREQ_RESET;
            max_freq_reg  <= MAX_FREQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEARTBEAT_INTERVAL: interval_reg  <= cfg_data[15:0];
                CFG_DEFAULT_FREQ:       dflt_freq_reg <= cfg_data[3:0];
                CFG_MIN_FREQ:           min_freq_reg  <= cfg_data[3:0];
                CFG_MAX_FREQ:           max_freq_reg  <= cfg_data[3:0];
                default:                interval_reg  <= interval_reg;
            endcase
        end
    end

    // capture the tick
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg         <= TIME_BITS'(in_item.now_ms);
            sleep_press_reg <= in_item.sleep_press;
            up_press_reg    <= in_item.up_press;
            down_press_reg  <= in_item.down_press;
            reset_press_reg <= in_item.reset_press;
        end
    end

    assign heart_elapsed = now_reg - heart_stamp_reg;
    assign pump_elapsed  = now_reg - pump_stamp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            heart_fire_reg <= heart_elapsed > TIME_BITS'(interval_reg);
            pump_fire_reg  <= pump_elapsed > TIME_BITS'(half_period_ms(freq_reg));
        end
    end

    always_comb
    begin
        mode_next        = mode_reg;
        freq_mid         = freq_reg;
        heart_level_next = heart_level_reg;
        heart_stamp_next = heart_stamp_reg;
        pump_phase_next  = pump_phase_reg;
        pump_stamp_next  = pump_stamp_reg;
        pump_pin_next    = pump_pin_reg;
        buzzer_pin_next  = buzzer_pin_reg;
        error_pin_next   = error_pin_reg;
        adjust_en_next   = adjust_en_reg;
        sleep_en_next    = sleep_en_reg;

        if (heart_fire_reg)
        begin
            heart_level_next = !heart_level_reg;
            heart_stamp_next = now_reg;
        end

        unique case (mode_reg)
            MODE_RUN:
            begin
                if (pump_fire_reg)
                begin
                    pump_pin_next   = !pump_pin_reg;
                    buzzer_pin_next = !buzzer_pin_reg;
                    pump_phase_next = !pump_phase_reg;
                    pump_stamp_next = now_reg;
                end
            end
            MODE_ENTRY:
            begin
                pump_pin_next   = pump_phase_reg;
                buzzer_pin_next = !pump_phase_reg;
                error_pin_next  = 1'b0;
                adjust_en_next  = 1'b1;
                sleep_en_next   = 1'b1;
                mode_next       = MODE_RUN;
            end
            MODE_SLEEP:
            begin
                pump_pin_next   = 1'b0;
                buzzer_pin_next = 1'b0;
                adjust_en_next  = 1'b0;
            end
            MODE_RESET:
            begin
                freq_mid  = {1'b0, dflt_freq_reg};
                mode_next = MODE_ENTRY;
            end
            default:
            begin
                pump_pin_next   = 1'b0;
                buzzer_pin_next = 1'b0;
                pump_phase_next = 1'b0;
                error_pin_next  = 1'b1;
                adjust_en_next  = 1'b0;
                sleep_en_next   = 1'b0;
                mode_next       = MODE_ERROR;
            end
        endcase

        if (sleep_press_reg && sleep_en_reg)
            mode_next = (mode_reg == MODE_SLEEP) ? MODE_ENTRY : MODE_SLEEP;

        freq_up = freq_mid;
        if (up_press_reg && adjust_en_reg && (freq_mid < FREQ_MAX_CODE))
            freq_up = freq_mid + 5'd1;
        freq_next = freq_up;
        if (down_press_reg && adjust_en_reg && (freq_up != 5'd0))
            freq_next = freq_up - 5'd1;

        if (((freq_next < {1'b0, min_freq_reg}) || (freq_next > {1'b0, max_freq_reg}))
            && (mode_reg != MODE_ERROR))
            mode_next = MODE_ERROR;

        if (reset_press_reg)
            mode_next = MODE_RESET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_RUN;
            freq_reg        <= {1'b0, DEFAULT_FREQ_RESET};
            heart_level_reg <= 1'b1;
            heart_stamp_reg <= '0;
            pump_phase_reg  <= 1'b1;
            pump_stamp_reg  <= '0;
            pump_pin_reg    <= 1'b1;
            buzzer_pin_reg  <= 1'b0;
            error_pin_reg   <= 1'b0;
            adjust_en_reg   <= 1'b1;
            sleep_en_reg    <= 1'b1;
        end
        else if (cmd.update)
        begin
            mode_reg        <= mode_next;
            freq_reg        <= freq_next;
            heart_level_reg <= heart_level_next;
            heart_stamp_reg <= heart_stamp_next;
            pump_phase_reg  <= pump_phase_next;
            pump_stamp_reg  <= pump_stamp_next;
            pump_pin_reg    <= pump_pin_next;
            buzzer_pin_reg  <= buzzer_pin_next;
            error_pin_reg   <= error_pin_next;
            adjust_en_reg   <= adjust_en_next;
            sleep_en_reg    <= sleep_en_next;
        end
    end

    always_comb
    begin
        res_item.heartbeat_on = heart_level_reg;
        res_item.pump_on      = pump_pin_reg;
        res_item.buzzer_on    = buzzer_pin_reg;
        res_item.error_on     = error_pin_reg;
        res_item.mode_now     = mode_reg;
        res_item.freq_now     = freq_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/led_blink_mode_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_mode_controller_unit: LED blink mode controller top level
// Each tick passes through the capture, compare and update steps of the
// sequencer before its result is valid, then waits for the result transfer.
// Only one tick is in flight at a time, so a new tick is taken only after the
// last result transfers, in the cycle after it. Results hold the LED levels,
// mode and frequency after the tick. Configuration writes are taken every
// cycle and belong between ticks.
// ----------------------------------------------------------------------------
module led_blink_mode_controller_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire lbm_pkg::in_item_t                     in_item,
    output logic                                       res_valid,
    input  wire logic                                  res_stall,
    output lbm_pkg::res_item_t                         res_item,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lbm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [lbm_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import lbm_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    lbm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_item  (res_item)
    );

endmodule
`default_nettype wire

// ===== rtl/lbm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbm_checker: port-level checks for the LED blink mode controller
// Watches the tick and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lbm_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic                  res_valid,
    input  wire logic                  res_stall,
    input  wire lbm_pkg::res_item_t    res_item
);
    import lbm_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second tick taken while one is in flight");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_stall)
        else $error("tick taken while result pending");

    a_result_delay: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##3 res_valid)
        else $error("result not ready three cycles after transfer");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_item.mode_now <= 3'(MODE_ERROR))
        else $error("mode out of range");

endmodule

bind led_blink_mode_controller_unit lbm_checker u_lbm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);
`default_nettype wire
